@@ rtl/core/mpsm_pkg.sv @@
// Shared constants, codes and helpers for the multi-pattern string matcher.
`default_nettype none
package mpsm_pkg;

  localparam int MAX_NODES    = 256;
  localparam int ALPHABET     = 26;
  localparam int MAX_PATTERNS = 64;

  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int CNT_W      = NODE_W + 1;
  localparam int SYM_W      = $clog2(ALPHABET);
  localparam int PAT_W      = $clog2(MAX_PATTERNS) + 1;
  localparam int GOTO_DEPTH = MAX_NODES * ALPHABET;
  localparam int SLOT_W     = $clog2(GOTO_DEPTH);
  localparam int CHAR_W     = 8;
  localparam int CMD_W      = 3;
  localparam int STAT_W     = 3;
  localparam int MASK_W     = 64;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  localparam logic [CHAR_W-1:0] BASE_RESET = 8'd97;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_END   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_BUILD = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MATCH = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

  localparam logic REG_ALPHA_BASE = 1'b0;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_ALPHA = 3'd2,
    ST_PATS  = 3'd3,
    ST_PHASE = 3'd4
  } status_e;

  typedef struct packed {
    logic              valid;
    logic [NODE_W-1:0] tgt;
  } edge_t;

  function automatic logic [SLOT_W-1:0] slot_addr(logic [NODE_W-1:0] n,
                                                  logic [SYM_W-1:0]  s);
    return SLOT_W'(n) * SLOT_W'(ALPHABET) + SLOT_W'(s);
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/mpsm_in_if.sv @@
// Input item channel of the matcher.
`default_nettype none
interface mpsm_in_if import mpsm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [CHAR_W-1:0] char_code;
  logic              new_text;

  modport source (output valid, cmd, char_code, new_text, input ready);
  modport sink   (input valid, cmd, char_code, new_text, output ready);
endinterface
`default_nettype wire

@@ rtl/core/mpsm_out_if.sv @@
// Result item channel of the matcher.
`default_nettype none
interface mpsm_out_if import mpsm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [MASK_W-1:0] match_mask;
  logic [NODE_W-1:0] state_index;
  logic [CNT_W-1:0]  node_count;

  modport source (output valid, status, match_mask, state_index, node_count, input ready);
  modport sink   (input valid, status, match_mask, state_index, node_count, output ready);
endinterface
`default_nettype wire

@@ rtl/core/multi_pattern_string_matcher.sv @@
// Aho-Corasick matcher top level: trie loader, link builder and text stepper.
//
// One item is in flight at a time; in_i.ready is high only while the sequencer
// is idle, and a finished result waits in an output register so the next item
// can be taken meanwhile. Every step goes through the single-port goto table
// (one read, registered) and its side memories. A match item follows fail
// links until the goto table has an edge for its symbol. Build scans every
// root symbol and root child, then takes trie nodes from a queue in
// breadth-first order, scans every symbol of each node and walks fail links
// for each child. After reset, and for a clear item, the goto table is swept
// once over all GOTO_DEPTH (6656) slots; no item is accepted during the sweep.
`default_nettype none
module multi_pattern_string_matcher import mpsm_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  mpsm_in_if.sink                in_i,
  mpsm_out_if.source             out_o
);

  typedef enum logic [5:0] {
    S_CLR, S_IDLE, S_LD_RD, S_LD_CHK, S_E_RD, S_E_WR,
    S_B_RM, S_B_RRD, S_B_RCHK, S_B_RA, S_B_RACC, S_B_DEQ,
    S_B_PF, S_B_FR, S_B_PF3, S_B_CH, S_B_CHK, S_B_WR, S_B_WK,
    S_B_WFR, S_B_WF, S_B_ATR, S_B_AT, S_B_ACR, S_B_AC,
    S_M_RD, S_M_CHK, S_M_FR, S_M_F, S_M_AR, S_M_A, S_OUT
  } state_e;

  state_e            state_q;
  logic [SLOT_W-1:0] clr_cnt_q;
  logic              clr_item_q;
  logic [CHAR_W-1:0] base_q;
  logic [CNT_W-1:0]  node_total_q;
  logic [PAT_W-1:0]  pats_q;
  logic [NODE_W-1:0] cursor_q, mstate_q;
  logic              built_q;
  logic [SYM_W-1:0]  sym_q;
  logic [NODE_W-1:0] p_q, fp_q, node_q, ch_q, tgt_q;
  logic [CNT_W-1:0]  head_q, tail_q;
  logic [MASK_W-1:0] root_mask_q, tmp_mask_q;
  status_e           res_status_q;
  logic [MASK_W-1:0] res_mask_q;
  logic [NODE_W-1:0] res_idx_q;
  logic              out_valid_q;
  status_e           out_status_q;
  logic [MASK_W-1:0] out_mask_q;
  logic [NODE_W-1:0] out_idx_q;
  logic [CNT_W-1:0]  out_cnt_q;

  // memories
  edge_t             gmem [GOTO_DEPTH];
  logic [MASK_W-1:0] amem [MAX_NODES];
  logic [NODE_W-1:0] fmem [MAX_NODES];
  logic [NODE_W-1:0] qmem [MAX_NODES];
  edge_t             g_rd_q;
  logic [MASK_W-1:0] a_rd_q;
  logic [NODE_W-1:0] f_rd_q, q_rd_q;

  logic [NODE_W-1:0] g_node;
  logic [SLOT_W-1:0] g_addr;
  logic              g_we;
  edge_t             g_wd;
  logic [NODE_W-1:0] a_raddr, a_waddr, f_raddr, f_wd;
  logic              a_we, f_we, q_we;
  logic [MASK_W-1:0] a_wd;
  logic [CHAR_W-1:0] sym8;
  logic              sym_ok, tbl_full, q_room, take, out_free;
  status_e           dec_status;
  state_e            dec_state;
  logic [NODE_W-1:0] dec_idx;

  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == REG_ALPHA_BASE) ? CFG_DW'(base_q) : '0;
  assign sym8    = in_i.char_code - base_q;
  assign sym_ok  = sym8 < CHAR_W'(ALPHABET);
  assign tbl_full = node_total_q >= CNT_W'(MAX_NODES);
  assign q_room  = tail_q < CNT_W'(MAX_NODES);
  assign take    = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.match_mask  = out_mask_q;
  assign out_o.state_index = out_idx_q;
  assign out_o.node_count  = out_cnt_q;

  always_comb begin
    dec_status = ST_OK;
    dec_state  = S_OUT;
    dec_idx    = '0;
    case (in_i.cmd)
      CMD_LOAD: begin
        dec_idx = cursor_q;
        if (built_q) dec_status = ST_PHASE;
        else if (pats_q[PAT_W-1]) dec_status = ST_PATS;
        else if (!sym_ok) dec_status = ST_ALPHA;
        else dec_state = S_LD_RD;
      end
      CMD_END: begin
        dec_idx = cursor_q;
        if (built_q) dec_status = ST_PHASE;
        else if (pats_q[PAT_W-1]) dec_status = ST_PATS;
        else dec_state = S_E_RD;
      end
      CMD_BUILD: begin
        if (built_q) dec_status = ST_PHASE;
        else dec_state = S_B_RM;
      end
      CMD_MATCH: begin
        if (!built_q) begin
          dec_status = ST_PHASE;
          dec_idx    = mstate_q;
        end else if (!sym_ok) begin
          dec_status = ST_ALPHA;
        end else begin
          dec_state = S_M_RD;
        end
      end
      CMD_CLEAR: dec_state = S_CLR;
      default: ;
    endcase
  end

  always_comb begin
    unique case (state_q)
      S_LD_RD, S_LD_CHK: g_node = cursor_q;
      S_B_RRD, S_B_RCHK: g_node = '0;
      S_B_CH:            g_node = p_q;
      default:           g_node = node_q;
    endcase
    g_addr = (state_q == S_CLR) ? clr_cnt_q : slot_addr(g_node, sym_q);
    g_we   = 1'b0;
    g_wd   = '0;
    a_raddr = '0;
    a_we    = 1'b0;
    a_waddr = '0;
    a_wd    = '0;
    f_raddr = node_q;
    f_we    = 1'b0;
    f_wd    = '0;
    q_we    = 1'b0;
    case (state_q)
      S_CLR: begin
        g_we = 1'b1;
        a_we = (clr_cnt_q == '0);
      end
      S_LD_CHK: begin
        g_we    = !g_rd_q.valid && !tbl_full;
        g_wd    = '{valid: 1'b1, tgt: node_total_q[NODE_W-1:0]};
        a_we    = g_we;
        a_waddr = node_total_q[NODE_W-1:0];
      end
      S_B_RCHK: begin
        g_we = !g_rd_q.valid;
        g_wd = '{valid: 1'b1, tgt: '0};
      end
      S_E_RD:           a_raddr = cursor_q;
      S_E_WR: begin
        a_we    = 1'b1;
        a_waddr = cursor_q;
        a_wd    = a_rd_q | (MASK_W'(1) << pats_q[PAT_W-2:0]);
      end
      S_B_RA, S_B_ACR:  a_raddr = ch_q;
      S_B_ATR, S_M_AR:  a_raddr = tgt_q;
      S_B_FR:           f_raddr = p_q;
      S_B_RACC: begin
        a_we    = 1'b1;
        a_waddr = ch_q;
        a_wd    = a_rd_q | root_mask_q;
        f_we    = 1'b1;
        q_we    = q_room;
      end
      S_B_AC: begin
        a_we    = 1'b1;
        a_waddr = ch_q;
        a_wd    = a_rd_q | tmp_mask_q;
        f_we    = 1'b1;
        f_wd    = tgt_q;
        q_we    = q_room;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (g_we) gmem[g_addr] <= g_wd;
    g_rd_q <= gmem[g_addr];
  end

  always_ff @(posedge clk_i) begin
    if (a_we) amem[a_waddr] <= a_wd;
    a_rd_q <= amem[a_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (f_we) fmem[ch_q] <= f_wd;
    f_rd_q <= fmem[f_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (q_we) qmem[tail_q[NODE_W-1:0]] <= ch_q;
    q_rd_q <= qmem[head_q[NODE_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      clr_cnt_q    <= '0;
      clr_item_q   <= 1'b0;
      base_q       <= BASE_RESET;
      node_total_q <= CNT_W'(1);
      pats_q       <= '0;
      cursor_q     <= '0;
      mstate_q     <= '0;
      built_q      <= 1'b0;
      head_q       <= '0;
      tail_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr[2] == REG_ALPHA_BASE) begin
        base_q <= pwdata[CHAR_W-1:0];
      end
      out_valid_q <= (state_q == S_OUT && out_free) || (out_valid_q && !out_o.ready);
      unique case (state_q)
        S_CLR: begin
          if (clr_cnt_q == SLOT_W'(GOTO_DEPTH - 1)) begin
            clr_cnt_q  <= '0;
            clr_item_q <= 1'b0;
            state_q    <= clr_item_q ? S_OUT : S_IDLE;
          end else begin
            clr_cnt_q <= clr_cnt_q + SLOT_W'(1);
          end
        end
        S_IDLE: begin
          if (take) begin
            res_status_q <= dec_status;
            res_mask_q   <= '0;
            res_idx_q    <= dec_idx;
            sym_q        <= (in_i.cmd == CMD_BUILD) ? '0 : sym8[SYM_W-1:0];
            state_q      <= dec_state;
            case (in_i.cmd)
              CMD_BUILD: begin
                if (!built_q) begin
                  head_q <= '0;
                  tail_q <= '0;
                end
              end
              CMD_MATCH: begin
                if (built_q && !sym_ok) mstate_q <= '0;
                node_q <= in_i.new_text ? '0 : mstate_q;
              end
              CMD_CLEAR: begin
                node_total_q <= CNT_W'(1);
                pats_q       <= '0;
                cursor_q     <= '0;
                mstate_q     <= '0;
                built_q      <= 1'b0;
                clr_cnt_q    <= '0;
                clr_item_q   <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_LD_RD: state_q <= S_LD_CHK;
        S_LD_CHK: begin
          state_q <= S_OUT;
          if (g_rd_q.valid) begin
            cursor_q  <= g_rd_q.tgt;
            res_idx_q <= g_rd_q.tgt;
          end else if (tbl_full) begin
            res_status_q <= ST_FULL;
          end else begin
            cursor_q     <= node_total_q[NODE_W-1:0];
            res_idx_q    <= node_total_q[NODE_W-1:0];
            node_total_q <= node_total_q + CNT_W'(1);
          end
        end
        S_E_RD: state_q <= S_E_WR;
        S_E_WR: begin
          pats_q    <= pats_q + PAT_W'(1);
          cursor_q  <= '0;
          res_idx_q <= '0;
          state_q   <= S_OUT;
        end
        S_B_RM: begin
          root_mask_q <= a_rd_q;
          state_q     <= S_B_RRD;
        end
        S_B_RRD: state_q <= S_B_RCHK;
        S_B_RCHK: begin
          if (g_rd_q.valid) begin
            ch_q    <= g_rd_q.tgt;
            state_q <= S_B_RA;
          end else if (sym_q == SYM_W'(ALPHABET - 1)) begin
            state_q <= S_B_DEQ;
          end else begin
            sym_q   <= sym_q + SYM_W'(1);
            state_q <= S_B_RRD;
          end
        end
        S_B_RA: state_q <= S_B_RACC;
        S_B_RACC: begin
          if (q_room) tail_q <= tail_q + CNT_W'(1);
          if (sym_q == SYM_W'(ALPHABET - 1)) state_q <= S_B_DEQ;
          else begin
            sym_q   <= sym_q + SYM_W'(1);
            state_q <= S_B_RRD;
          end
        end
        S_B_DEQ: begin
          if (head_q < tail_q) begin
            head_q  <= head_q + CNT_W'(1);
            state_q <= S_B_PF;
          end else begin
            built_q   <= 1'b1;
            mstate_q  <= '0;
            res_idx_q <= '0;
            state_q   <= S_OUT;
          end
        end
        S_B_PF: begin
          p_q     <= q_rd_q;
          state_q <= S_B_FR;
        end
        S_B_FR: state_q <= S_B_PF3;
        S_B_PF3: begin
          fp_q    <= f_rd_q;
          sym_q   <= '0;
          state_q <= S_B_CH;
        end
        S_B_CH: state_q <= S_B_CHK;
        S_B_CHK: begin
          if (g_rd_q.valid) begin
            ch_q    <= g_rd_q.tgt;
            node_q  <= fp_q;
            state_q <= S_B_WR;
          end else if (sym_q == SYM_W'(ALPHABET - 1)) begin
            state_q <= S_B_DEQ;
          end else begin
            sym_q   <= sym_q + SYM_W'(1);
            state_q <= S_B_CH;
          end
        end
        S_B_WR: state_q <= S_B_WK;
        S_B_WK: begin
          if (g_rd_q.valid) begin
            tgt_q   <= g_rd_q.tgt;
            state_q <= S_B_ATR;
          end else begin
            state_q <= S_B_WFR;
          end
        end
        S_B_WFR: state_q <= S_B_WF;
        S_B_WF: begin
          node_q  <= f_rd_q;
          state_q <= S_B_WR;
        end
        S_B_ATR: state_q <= S_B_AT;
        S_B_AT: begin
          tmp_mask_q <= a_rd_q;
          state_q    <= S_B_ACR;
        end
        S_B_ACR: state_q <= S_B_AC;
        S_B_AC: begin
          if (q_room) tail_q <= tail_q + CNT_W'(1);
          if (sym_q == SYM_W'(ALPHABET - 1)) state_q <= S_B_DEQ;
          else begin
            sym_q   <= sym_q + SYM_W'(1);
            state_q <= S_B_CH;
          end
        end
        S_M_RD: state_q <= S_M_CHK;
        S_M_CHK: begin
          if (g_rd_q.valid) begin
            tgt_q    <= g_rd_q.tgt;
            mstate_q <= g_rd_q.tgt;
            state_q  <= S_M_AR;
          end else begin
            state_q <= S_M_FR;
          end
        end
        S_M_FR: state_q <= S_M_F;
        S_M_F: begin
          node_q  <= f_rd_q;
          state_q <= S_M_RD;
        end
        S_M_AR: state_q <= S_M_A;
        S_M_A: begin
          res_mask_q <= a_rd_q;
          res_idx_q  <= mstate_q;
          state_q    <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_status_q <= res_status_q;
            out_mask_q   <= res_mask_q;
            out_idx_q    <= res_idx_q;
            out_cnt_q    <= node_total_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> !in_i.ready) else $error("ready held after item taken");

  a_match_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    built_q |-> ({1'b0, mstate_q} < node_total_q)) else $error("match state beyond trie");

  a_cursor_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cursor_q} < node_total_q)) else $error("load cursor beyond trie");

  a_queue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q) else $error("queue head passed tail");

endmodule
`default_nettype wire
